// ===== sv/yakb_pkg.sv =====
// yakb_pkg: shared types, constants and helpers for the YUV alpha key blender.
// Used by yakb_lane, yakb_ctrl, yakb_merge and yuv_alpha_key_blend.
// No dependencies.
package yakb_pkg;

  // Sample, weight and product widths
  localparam int SAMPLE_W = 10;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int CFG_IDX_W = 2;

  // Full-scale values and their log2 (M = 2^k - 1)
  localparam logic [SAMPLE_W-1:0] FULL_8BIT  = 10'd255;
  localparam logic [SAMPLE_W-1:0] FULL_10BIT = 10'd1023;
  localparam int SHIFT_8BIT  = 8;
  localparam int SHIFT_10BIT = 10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_MODE   = 2'd0,
    CFG_WEIGHT_SOURCE = 2'd1,
    CFG_MIX_WEIGHT    = 2'd2
  } cfg_idx_t;

  // Per-stage advance enables of the pipeline
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

  // Sideband carried beside each word
  typedef struct packed {
    logic chroma_on;
    logic line_end;
  } side_t;

  // Full scale for the sample mode: 0 = 8-bit, 1 = 10-bit
  function automatic logic [SAMPLE_W-1:0] full_scale(input logic mode);
    return mode ? FULL_10BIT : FULL_8BIT;
  endfunction

  // Saturate a value to the full scale
  function automatic logic [SAMPLE_W-1:0] sat_full(input logic [SAMPLE_W-1:0] v,
                                                   input logic mode);
    logic [SAMPLE_W-1:0] m;
    m = full_scale(mode);
    return (v > m) ? m : v;
  endfunction

endpackage

// ===== sv/yakb_lane.sv =====
// yakb_lane: one blend lane, floor((f*w + b*(M-w)) / M) in three stages.
// Depends on yakb_pkg; enables come from yakb_ctrl.
module yakb_lane (
  input  logic                              clk,
  input  yakb_pkg::stage_en_t               en,
  input  logic                              mode,
  input  logic [yakb_pkg::SAMPLE_W-1:0]     fg,
  input  logic [yakb_pkg::SAMPLE_W-1:0]     bg,
  input  logic [yakb_pkg::SAMPLE_W-1:0]     w,
  output logic [yakb_pkg::SAMPLE_W-1:0]     result
);
  import yakb_pkg::*;

  logic [SAMPLE_W-1:0] m;
  logic [SAMPLE_W-1:0] f_sat;
  logic [SAMPLE_W-1:0] b_sat;
  logic [SAMPLE_W-1:0] w_inv;
  logic [PROD_W-1:0]   fg_prod_nxt, fg_prod_r;
  logic [PROD_W-1:0]   bg_prod_nxt, bg_prod_r;
  logic [PROD_W:0]     sum_w;
  logic [PROD_W-1:0]   mix_nxt, mix_r;
  logic [PROD_W:0]     est_w;
  logic [SAMPLE_W-1:0] est_nxt, est_r;
  logic [PROD_W-1:0]   back_w;
  logic [PROD_W-1:0]   rem_w;

  assign m = full_scale(mode);

  // Stage 1: saturate samples and form both weighted products
  always_comb begin
    f_sat       = sat_full(fg, mode);
    b_sat       = sat_full(bg, mode);
    w_inv       = m - w;
    fg_prod_nxt = f_sat * w;
    bg_prod_nxt = b_sat * w_inv;
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      fg_prod_r <= fg_prod_nxt;
      bg_prod_r <= bg_prod_nxt;
    end
  end

  // Stage 2: add products, estimate quotient by x/(2^k-1) ~ (x + x>>k) >> k.
  // The estimate is exact or one low; the sum never exceeds M*M.
  always_comb begin
    sum_w   = {1'b0, fg_prod_r} + {1'b0, bg_prod_r};
    mix_nxt = sum_w[PROD_W-1:0];
    if (mode) begin
      est_w   = {1'b0, mix_nxt} + ({1'b0, mix_nxt} >> SHIFT_10BIT);
      est_nxt = est_w[SHIFT_10BIT +: SAMPLE_W];
    end else begin
      est_w   = {1'b0, mix_nxt} + ({1'b0, mix_nxt} >> SHIFT_8BIT);
      est_nxt = est_w[SHIFT_8BIT +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      mix_r <= mix_nxt;
      est_r <= est_nxt;
    end
  end

  // Stage 3: remainder check, bump the estimate when remainder reaches M
  always_comb begin
    if (mode) begin
      back_w = {est_r, {SHIFT_10BIT{1'b0}}} - PROD_W'(est_r);
    end else begin
      back_w = {{(PROD_W-SAMPLE_W-SHIFT_8BIT){1'b0}}, est_r, {SHIFT_8BIT{1'b0}}}
               - PROD_W'(est_r);
    end
    rem_w  = mix_r - back_w;
    result = (rem_w >= PROD_W'(m)) ? est_r + 1'b1 : est_r;
  end

endmodule

// ===== sv/yakb_ctrl.sv =====
// yakb_ctrl: valid tracking, stage enables, line parity and sideband pipe.
// Depends on yakb_pkg.
module yakb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_line_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output yakb_pkg::stage_en_t  en,
  output yakb_pkg::side_t      side_s2
);
  import yakb_pkg::*;

  logic  v1_r, v2_r, v3_r;
  logic  odd_line_r, odd_line_nxt;
  logic  in_acc;
  side_t side_in;
  side_t side1_r, side2_r;

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    en.en3 = !v3_r || out_ready;
    en.en2 = !v2_r || en.en3;
    en.en1 = !v1_r || en.en2;
  end

  assign in_ready  = en.en1;
  assign out_valid = v3_r;
  assign in_acc    = in_valid && en.en1;
  assign side_s2   = side2_r;

  // Chroma is produced on every line in 10-bit mode, on even lines in 8-bit mode
  always_comb begin
    side_in.chroma_on = mode || !odd_line_r;
    side_in.line_end  = in_line_end;
    odd_line_nxt      = odd_line_r ^ (in_acc && in_line_end);
  end

  // Hold valid bits and parity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      odd_line_r <= 1'b0;
    end else begin
      odd_line_r <= odd_line_nxt;
      if (en.en1) begin
        v1_r <= in_valid;
      end
      if (en.en2) begin
        v2_r <= v1_r;
      end
      if (en.en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Advance sideband with the data
  always_ff @(posedge clk) begin
    if (en.en1) begin
      side1_r <= side_in;
    end
    if (en.en2) begin
      side2_r <= side1_r;
    end
  end

`ifndef SYNTHESIS
  a_parity_flip: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_line_end |=> odd_line_r != $past(odd_line_r))
    else $error("line parity did not toggle on line end");

  a_parity_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !(in_valid && in_ready && in_line_end)
    |=> odd_line_r == $past(odd_line_r))
    else $error("line parity changed without line end");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full and stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ready)
    else $error("input refused while first stage is empty");
`endif

endmodule

// ===== sv/yakb_merge.sv =====
// yakb_merge: output register that gathers the four lane results and
// gates chroma by the line sideband. Depends on yakb_pkg.
module yakb_merge (
  input  logic                          clk,
  input  yakb_pkg::stage_en_t           en,
  input  yakb_pkg::side_t               side_s2,
  input  logic [yakb_pkg::SAMPLE_W-1:0] luma_even,
  input  logic [yakb_pkg::SAMPLE_W-1:0] luma_odd,
  input  logic [yakb_pkg::SAMPLE_W-1:0] chroma_u,
  input  logic [yakb_pkg::SAMPLE_W-1:0] chroma_v,
  output logic [yakb_pkg::SAMPLE_W-1:0] out_luma_even,
  output logic [yakb_pkg::SAMPLE_W-1:0] out_luma_odd,
  output logic [yakb_pkg::SAMPLE_W-1:0] out_chroma_u,
  output logic [yakb_pkg::SAMPLE_W-1:0] out_chroma_v,
  output logic                          out_chroma_valid,
  output logic                          out_line_end
);
  import yakb_pkg::*;

  logic [SAMPLE_W-1:0] luma_even_r, luma_odd_r, chroma_u_r, chroma_v_r;
  logic [SAMPLE_W-1:0] chroma_u_nxt, chroma_v_nxt;
  side_t               side_r;

  // Drop chroma on lines without it
  always_comb begin
    chroma_u_nxt = side_s2.chroma_on ? chroma_u : '0;
    chroma_v_nxt = side_s2.chroma_on ? chroma_v : '0;
  end

  // Hold the finished word until taken
  always_ff @(posedge clk) begin
    if (en.en3) begin
      luma_even_r <= luma_even;
      luma_odd_r  <= luma_odd;
      chroma_u_r  <= chroma_u_nxt;
      chroma_v_r  <= chroma_v_nxt;
      side_r      <= side_s2;
    end
  end

  assign out_luma_even    = luma_even_r;
  assign out_luma_odd     = luma_odd_r;
  assign out_chroma_u     = chroma_u_r;
  assign out_chroma_v     = chroma_v_r;
  assign out_chroma_valid = side_r.chroma_on;
  assign out_line_end     = side_r.line_end;

endmodule

// ===== sv/yuv_alpha_key_blend.sv =====
// yuv_alpha_key_blend: keyed or constant-weight mix of a foreground pixel pair
// over the background pair. Depends on yakb_pkg, yakb_lane, yakb_ctrl, yakb_merge.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid/in_ready   | fg/bg pair, two keys, line end
//   out     | output    | out_valid/out_ready | blended pair, chroma flag, line end
//   cfg     | input     | cfg_valid/cfg_ready | register index and data
//
// One word per cycle while out_ready holds or the pipeline has an empty stage.
// Four lanes (two luma, U, V) each multiply, add with a quotient estimate, then
// correct by one remainder compare; the output register is the last stage.
// Reset is synchronous; it clears the configuration registers, valid bits and line parity.
// A stalled output holds every stage behind it; empty stages still fill.
module yuv_alpha_key_blend (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [yakb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_fg_luma_even,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_fg_luma_odd,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_fg_chroma_u,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_fg_chroma_v,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_key_even,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_key_odd,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_bg_luma_even,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_bg_luma_odd,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_bg_chroma_u,
  input  logic [yakb_pkg::SAMPLE_W-1:0]   in_bg_chroma_v,
  input  logic                            in_line_end,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [yakb_pkg::SAMPLE_W-1:0]   out_luma_even,
  output logic [yakb_pkg::SAMPLE_W-1:0]   out_luma_odd,
  output logic [yakb_pkg::SAMPLE_W-1:0]   out_chroma_u,
  output logic [yakb_pkg::SAMPLE_W-1:0]   out_chroma_v,
  output logic                            out_chroma_valid,
  output logic                            out_line_end
);
  import yakb_pkg::*;

  logic                sample_mode_r;
  logic                weight_source_r;
  logic [SAMPLE_W-1:0] mix_weight_r;
  logic [SAMPLE_W-1:0] w_even, w_odd;
  stage_en_t           en;
  side_t               side_s2;
  logic [SAMPLE_W-1:0] res_luma_even, res_luma_odd, res_chroma_u, res_chroma_v;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_mode_r   <= 1'b0;
      weight_source_r <= 1'b0;
      mix_weight_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_MODE:   sample_mode_r   <= cfg_data[0];
        CFG_WEIGHT_SOURCE: weight_source_r <= cfg_data[0];
        CFG_MIX_WEIGHT:    mix_weight_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick per-pixel key or constant weight, saturated to full scale
  always_comb begin
    if (weight_source_r) begin
      w_even = sat_full(mix_weight_r, sample_mode_r);
      w_odd  = w_even;
    end else begin
      w_even = sat_full(in_key_even, sample_mode_r);
      w_odd  = sat_full(in_key_odd, sample_mode_r);
    end
  end

  yakb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode        (sample_mode_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_line_end (in_line_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .en          (en),
    .side_s2     (side_s2)
  );

  yakb_lane u_lane_luma_even (
    .clk    (clk),
    .en     (en),
    .mode   (sample_mode_r),
    .fg     (in_fg_luma_even),
    .bg     (in_bg_luma_even),
    .w      (w_even),
    .result (res_luma_even)
  );

  yakb_lane u_lane_luma_odd (
    .clk    (clk),
    .en     (en),
    .mode   (sample_mode_r),
    .fg     (in_fg_luma_odd),
    .bg     (in_bg_luma_odd),
    .w      (w_odd),
    .result (res_luma_odd)
  );

  yakb_lane u_lane_chroma_u (
    .clk    (clk),
    .en     (en),
    .mode   (sample_mode_r),
    .fg     (in_fg_chroma_u),
    .bg     (in_bg_chroma_u),
    .w      (w_even),
    .result (res_chroma_u)
  );

  yakb_lane u_lane_chroma_v (
    .clk    (clk),
    .en     (en),
    .mode   (sample_mode_r),
    .fg     (in_fg_chroma_v),
    .bg     (in_bg_chroma_v),
    .w      (w_even),
    .result (res_chroma_v)
  );

  yakb_merge u_merge (
    .clk              (clk),
    .en               (en),
    .side_s2          (side_s2),
    .luma_even        (res_luma_even),
    .luma_odd         (res_luma_odd),
    .chroma_u         (res_chroma_u),
    .chroma_v         (res_chroma_v),
    .out_luma_even    (out_luma_even),
    .out_luma_odd     (out_luma_odd),
    .out_chroma_u     (out_chroma_u),
    .out_chroma_v     (out_chroma_v),
    .out_chroma_valid (out_chroma_valid),
    .out_line_end     (out_line_end)
  );

endmodule
